FILE: sv/rcfc_pkg.sv
`default_nettype none

package rcfc_pkg;

	localparam int unsigned KeyBytes  = 32;
	localparam int unsigned KeyBits   = KeyBytes * 8;
	localparam int unsigned WordBits  = 64;

	// configuration register indexes
	localparam logic [1:0] REG_TABLE_0 = 2'd0;
	localparam logic [1:0] REG_TABLE_1 = 2'd1;
	localparam logic [1:0] REG_TABLE_2 = 2'd2;
	localparam logic [1:0] REG_TABLE_3 = 2'd3;

	localparam logic [7:0] KEY_BIAS  = 8'h25;
	localparam logic [7:0] MASK_LOW  = 8'he0;
	localparam logic [7:0] MASK_HIGH = 8'h07;
	localparam logic [7:0] NIB_MASK  = 8'h0f;
	localparam logic [3:0] BTN_CHECK = 4'hc;

	typedef enum logic {
		MODE_GEN = 1'b0,
		MODE_DEC = 1'b1
	} mode_t;

	// one beat in flight: six working bytes plus the byte kept beside the cipher
	typedef struct packed {
		mode_t           mode;
		logic [7:0]      hdr;
		logic [5:0][7:0] b;
	} stage_t;

	typedef struct packed {
		logic use_high;
		logic do_swap;
	} mix_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/rcfc_mix.sv
`default_nettype none

module rcfc_mix (
	input  wire logic [rcfc_pkg::KeyBits-1:0] key,
	input  wire rcfc_pkg::stage_t              d,
	input  wire rcfc_pkg::mix_ctrl_t           ctrl,
	output rcfc_pkg::stage_t                   q
);

	logic [4:0] idx;
	logic [7:0] kb;
	logic [7:0] k;
	logic [7:0] m;
	logic [7:0] t;

	always_comb begin
		idx = ctrl.use_high ? d.b[0][7:3] : d.b[0][4:0];
		kb  = key[{idx, 3'b000} +: 8];
		k   = ctrl.use_high ? kb + rcfc_pkg::KEY_BIAS : kb;
		m   = ctrl.use_high ? rcfc_pkg::MASK_HIGH : rcfc_pkg::MASK_LOW;
		q   = d;
		for (int i = 1; i < 6; i++) begin
			q.b[i] = d.b[i] ^ k;
		end
		q.b[5] = q.b[5] & rcfc_pkg::NIB_MASK;
		q.b[0] = d.b[0] ^ (k & m);
		if (ctrl.do_swap) begin
			t      = q.b[0];
			q.b[0] = q.b[1];
			q.b[1] = t;
		end else begin
			t = 8'h00;
		end
	end

endmodule

`default_nettype wire

FILE: sv/rcfc_fmt.sv
`default_nettype none

module rcfc_fmt (
	input  wire rcfc_pkg::stage_t d,
	output logic [51:0]           frame,
	output logic [27:0]           serial,
	output logic [3:0]            button,
	output logic [15:0]           counter
);

	always_comb begin
		frame   = '0;
		serial  = '0;
		button  = '0;
		counter = '0;
		if (d.mode == rcfc_pkg::MODE_GEN) begin
			// inverting byte permutation, button byte on top
			frame = {d.hdr, ~d.b[5][3:0], ~d.b[0], ~d.b[1], ~d.b[4], ~d.b[3], ~d.b[2]};
		end else begin
			serial  = {d.b[5][3:0], d.b[4], d.b[3], d.b[2]};
			counter = {d.b[1], d.b[0]};
			button  = d.hdr[3:0];
		end
	end

endmodule

`default_nettype wire

FILE: sv/rolling_code_frame_cipher.sv
// Rolling-code frame cipher.
// Input channel (in_valid / in_stall): mode 0 builds a 52-bit frame from
// serial_in, counter_in and button_in; mode 1 opens frame_in and returns
// serial, counter and button. One result beat per input beat, in order.
// Output channel (out_valid / out_stall) carries all four result fields; the
// fields that do not belong to the mode read zero.
// Key table: four 64-bit words written through cfg_we / cfg_index / cfg_data.
// Write them only while no beat is in flight; the block does not enforce this.
// Reset clears the table to zeros. The accept edge loads the input register,
// then the beat passes four mix stages (one key-byte lookup each, plus an
// 8-bit add in the high-index stages) and the output register.
// Throughput is one beat per cycle while out_stall does not hold the pipeline.
// When out_stall is high the pipeline keeps shifting into empty stages, so
// in_stall rises only once every stage holds a beat; nothing is dropped.
// Reset empties the pipeline; out_valid is low out of reset.
`default_nettype none

module rolling_code_frame_cipher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [27:0] serial_in,
	input  wire logic [3:0]  button_in,
	input  wire logic [15:0] counter_in,
	input  wire logic [51:0] frame_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [51:0]      frame_out,
	output logic [27:0]      serial_out,
	output logic [3:0]       button_out,
	output logic [15:0]      counter_out
);

	logic [rcfc_pkg::KeyBits-1:0] key_q;

	rcfc_pkg::stage_t prep;
	rcfc_pkg::stage_t data_s1, data_s2, data_s3, data_s4, data_s5;
	rcfc_pkg::stage_t mix2, mix3, mix4, mix5;
	rcfc_pkg::mix_ctrl_t ctrl2, ctrl3, ctrl4, ctrl5;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic [51:0] fmt_frame;
	logic [27:0] fmt_serial;
	logic [3:0]  fmt_button;
	logic [15:0] fmt_counter;
	logic [51:0] frame_s6;
	logic [27:0] serial_s6;
	logic [3:0]  button_s6;
	logic [15:0] counter_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rcfc_pkg::REG_TABLE_0: key_q[0*rcfc_pkg::WordBits +: rcfc_pkg::WordBits] <= cfg_data;
				rcfc_pkg::REG_TABLE_1: key_q[1*rcfc_pkg::WordBits +: rcfc_pkg::WordBits] <= cfg_data;
				rcfc_pkg::REG_TABLE_2: key_q[2*rcfc_pkg::WordBits +: rcfc_pkg::WordBits] <= cfg_data;
				rcfc_pkg::REG_TABLE_3: key_q[3*rcfc_pkg::WordBits +: rcfc_pkg::WordBits] <= cfg_data;
				default: key_q <= key_q;
			endcase
		end
	end

	// plaintext bytes for generate, undo of the output permutation for decode
	always_comb begin
		prep.mode = rcfc_pkg::mode_t'(mode);
		if (mode == rcfc_pkg::MODE_GEN) begin
			prep.hdr  = {button_in, button_in ^ rcfc_pkg::BTN_CHECK};
			prep.b[0] = counter_in[7:0];
			prep.b[1] = counter_in[15:8];
			prep.b[2] = serial_in[7:0];
			prep.b[3] = serial_in[15:8];
			prep.b[4] = serial_in[23:16];
			prep.b[5] = {4'h0, serial_in[27:24]};
		end else begin
			prep.hdr  = {4'h0, frame_in[51:48]};
			prep.b[0] = ~frame_in[39:32];
			prep.b[1] = ~frame_in[31:24];
			prep.b[2] = ~frame_in[7:0];
			prep.b[3] = ~frame_in[15:8];
			prep.b[4] = ~frame_in[23:16];
			prep.b[5] = ~frame_in[47:40];
		end
	end

	// stall chain: a stage moves when it is empty or the next one moves
	assign rdy6     = !valid_s6 || !out_stall;
	assign rdy5     = !valid_s5 || rdy6;
	assign rdy4     = !valid_s4 || rdy5;
	assign rdy3     = !valid_s3 || rdy4;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_stall = !rdy1;

	// generate: low, high+swap, low, high; decode: high, low+swap, high, low
	assign ctrl2 = '{use_high: data_s1.mode == rcfc_pkg::MODE_DEC, do_swap: 1'b0};
	assign ctrl3 = '{use_high: data_s2.mode == rcfc_pkg::MODE_GEN, do_swap: 1'b1};
	assign ctrl4 = '{use_high: data_s3.mode == rcfc_pkg::MODE_DEC, do_swap: 1'b0};
	assign ctrl5 = '{use_high: data_s4.mode == rcfc_pkg::MODE_GEN, do_swap: 1'b0};

	rcfc_mix u_mix2 (.key(key_q), .d(data_s1), .ctrl(ctrl2), .q(mix2));
	rcfc_mix u_mix3 (.key(key_q), .d(data_s2), .ctrl(ctrl3), .q(mix3));
	rcfc_mix u_mix4 (.key(key_q), .d(data_s3), .ctrl(ctrl4), .q(mix4));
	rcfc_mix u_mix5 (.key(key_q), .d(data_s4), .ctrl(ctrl5), .q(mix5));

	rcfc_fmt u_fmt (
		.d      (data_s5),
		.frame  (fmt_frame),
		.serial (fmt_serial),
		.button (fmt_button),
		.counter(fmt_counter)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
			if (rdy4) valid_s4 <= valid_s3;
			if (rdy5) valid_s5 <= valid_s4;
			if (rdy6) valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) data_s1 <= prep;
		if (rdy2 && valid_s1) data_s2 <= mix2;
		if (rdy3 && valid_s2) data_s3 <= mix3;
		if (rdy4 && valid_s3) data_s4 <= mix4;
		if (rdy5 && valid_s4) data_s5 <= mix5;
		if (rdy6 && valid_s5) begin
			frame_s6   <= fmt_frame;
			serial_s6  <= fmt_serial;
			button_s6  <= fmt_button;
			counter_s6 <= fmt_counter;
		end
	end

	assign out_valid   = valid_s6;
	assign frame_out   = frame_s6;
	assign serial_out  = serial_s6;
	assign button_out  = button_s6;
	assign counter_out = counter_s6;

endmodule

`default_nettype wire
